// File: rtl/g2e_pkg.sv
package g2e_pkg;

  localparam int CORDIC_ITERATIONS = 32;
  localparam int ITER_W = 6;
  localparam int ANG_W = 35;
  localparam int XY_W = 34;
  localparam int MAG_W = 32;
  localparam int ALT_W = 32;
  localparam int AXIS_W = 33;
  localparam int RATIO_W = 32;
  localparam int NUM_W = 64;
  localparam int ROOT_W = 32;
  localparam int SQ_REM_W = 36;
  localparam int QUO_W = 35;
  localparam int DREM_W = 33;
  localparam int PROD_R_W = 34;
  localparam int SUM_W = 37;
  localparam int POS_W = 35;
  localparam int LATENCY = CORDIC_ITERATIONS + ROOT_W + QUO_W + 8;

  localparam logic signed [ANG_W-1:0] PI_Q30 = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [SUM_W-1:0] INNER_LIMIT = 37'sd12000000000;
  localparam logic signed [SUM_W-1:0] OUT_LIMIT = 37'sd9000000000;
  localparam logic [QUO_W-1:0] QUO_LIMIT = 35'd12000000000;
  localparam logic [AXIS_W-1:0] AXIS_RESET = 33'd6378137000;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 32'd4280567084;
  localparam logic [NUM_W-1:0] ROUND_HALF = NUM_W'(64'd1 << 29);

  typedef enum logic [0:0] {
    CFG_SEMI_MAJOR = 1'b0,
    CFG_AXIS_RATIO = 1'b1
  } cfg_idx_e;

  localparam logic signed [ANG_W-1:0] ATAN_TAB [11] = '{
    35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
    35'sd67021687, 35'sd33543516, 35'sd16775851, 35'sd8388437,
    35'sd4194283, 35'sd2097149, 35'sd1048576
  };

  typedef struct packed {
    logic                    flip_lat;
    logic                    flip_lon;
    logic signed [ALT_W-1:0] alt;
  } cordic_pl_t;

  typedef struct packed {
    logic                    c_neg;
    logic                    s_neg;
    logic                    xa_neg;
    logic                    za_neg;
    logic [PROD_R_W-1:0]     altc;
    logic [PROD_R_W-1:0]     alts;
    logic [NUM_W-1:0]        num_x;
    logic [NUM_W-1:0]        num_z;
    logic signed [XY_W-1:0]  cl;
    logic signed [XY_W-1:0]  sl;
  } sqrt_pl_t;

  typedef struct packed {
    logic                    c_neg;
    logic                    s_neg;
    logic                    xa_neg;
    logic                    za_neg;
    logic [PROD_R_W-1:0]     altc;
    logic [PROD_R_W-1:0]     alts;
    logic signed [XY_W-1:0]  cl;
    logic signed [XY_W-1:0]  sl;
    logic                    ovf_x;
    logic                    ovf_z;
    logic [ROOT_W-1:0]       den;
  } div_pl_t;

  function automatic logic signed [ANG_W-1:0] atan_step(input logic [ITER_W-1:0] i);
    logic signed [ANG_W-1:0] r;
    logic [ANG_W-1:0] one;
    one = ANG_W'(1);
    if (i < ITER_W'(11)) begin
      r = ATAN_TAB[i[3:0]];
    end else if (i <= ITER_W'(30)) begin
      r = $signed(one << (ITER_W'(30) - i));
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] mag(input logic signed [XY_W-1:0] v);
    logic [XY_W-1:0] a;
    a = v[XY_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] clamp(input logic signed [SUM_W-1:0] v,
                                                     input logic signed [SUM_W-1:0] lim);
    logic signed [SUM_W-1:0] r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/g2e_cordic_cell.sv
module g2e_cordic_cell (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [g2e_pkg::ITER_W-1:0]          iter_i,
  input  logic signed [g2e_pkg::XY_W-1:0]     x_i,
  input  logic signed [g2e_pkg::XY_W-1:0]     y_i,
  input  logic signed [g2e_pkg::ANG_W-1:0]    z_i,
  output logic signed [g2e_pkg::XY_W-1:0]     x_o,
  output logic signed [g2e_pkg::XY_W-1:0]     y_o,
  output logic signed [g2e_pkg::ANG_W-1:0]    z_o
);

  logic signed [g2e_pkg::XY_W-1:0]  x_d, y_d, x_q, y_q, dx, dy;
  logic signed [g2e_pkg::ANG_W-1:0] z_d, z_q, step;

  always_comb begin
    dx   = y_i >>> iter_i;
    dy   = x_i >>> iter_i;
    step = g2e_pkg::atan_step(iter_i);
    if (!z_i[g2e_pkg::ANG_W-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - step;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// File: rtl/g2e_sqrt_cell.sv
module g2e_sqrt_cell (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [g2e_pkg::NUM_W-1:0]      rad_i,
  input  logic [g2e_pkg::SQ_REM_W-1:0]   rem_i,
  input  logic [g2e_pkg::ROOT_W-1:0]     root_i,
  output logic [g2e_pkg::NUM_W-1:0]      rad_o,
  output logic [g2e_pkg::SQ_REM_W-1:0]   rem_o,
  output logic [g2e_pkg::ROOT_W-1:0]     root_o
);

  logic [g2e_pkg::SQ_REM_W-1:0] rem_sh, trial, rem_d, rem_q;
  logic [g2e_pkg::ROOT_W-1:0]   root_d, root_q;
  logic [g2e_pkg::NUM_W-1:0]    rad_q;

  always_comb begin
    rem_sh = {rem_i[g2e_pkg::SQ_REM_W-3:0], rad_i[g2e_pkg::NUM_W-1 -: 2]};
    trial  = g2e_pkg::SQ_REM_W'({root_i, 2'b01});
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_i[g2e_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_i[g2e_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_i << 2;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// File: rtl/g2e_div_cell.sv
module g2e_div_cell (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [g2e_pkg::ROOT_W-1:0]    den_i,
  input  logic [g2e_pkg::NUM_W-1:0]     num_i,
  input  logic [g2e_pkg::DREM_W-1:0]    rem_i,
  input  logic [g2e_pkg::QUO_W-1:0]     quo_i,
  output logic [g2e_pkg::NUM_W-1:0]     num_o,
  output logic [g2e_pkg::DREM_W-1:0]    rem_o,
  output logic [g2e_pkg::QUO_W-1:0]     quo_o
);

  logic [g2e_pkg::DREM_W-1:0] rem_sh, den_ext, rem_d, rem_q;
  logic [g2e_pkg::QUO_W-1:0]  quo_d, quo_q;
  logic [g2e_pkg::NUM_W-1:0]  num_q;

  always_comb begin
    rem_sh  = {rem_i[g2e_pkg::DREM_W-2:0], num_i[g2e_pkg::NUM_W-1]};
    den_ext = g2e_pkg::DREM_W'(den_i);
    if (rem_sh >= den_ext) begin
      rem_d = rem_sh - den_ext;
      quo_d = {quo_i[g2e_pkg::QUO_W-2:0], 1'b1};
    end else begin
      rem_d = rem_sh;
      quo_d = {quo_i[g2e_pkg::QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_i << 1;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign num_o = num_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

// File: rtl/geodetic_to_ecef.sv
// Data flows through the CORDIC, square-root and divider cell rows, each of which
// retires one step per cycle while the pipeline advances.
// Throughput is one beat per cycle; the whole pipeline holds while a result waits.
// Reset empties the pipeline and loads the WGS84 semi-major axis and axis ratio.
// The squared axis ratio is registered from the stored ratio and follows each write.
module geodetic_to_ecef (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_addr_i,
  input  logic [32:0]   cfg_wdata_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [95:0]   s_axis_tdata,  // latitude, longitude, altitude_mm, pad
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [111:0]  m_axis_tdata   // pos_x_mm, pos_y_mm, pos_z_mm, pad
);

  localparam int N  = g2e_pkg::CORDIC_ITERATIONS;
  localparam int NS = g2e_pkg::ROOT_W;
  localparam int ND = g2e_pkg::QUO_W;
  localparam int L  = g2e_pkg::LATENCY;
  localparam int XW = g2e_pkg::XY_W;
  localparam int AW = g2e_pkg::ANG_W;
  localparam int MW = g2e_pkg::MAG_W;
  localparam int NW = g2e_pkg::NUM_W;
  localparam int SW = g2e_pkg::SUM_W;
  localparam int PW = g2e_pkg::POS_W;
  localparam int RW = g2e_pkg::PROD_R_W;

  logic                              adv;
  logic [L-1:0]                      vld_q;
  logic [g2e_pkg::AXIS_W-1:0]        semi_q;
  logic [g2e_pkg::RATIO_W-1:0]       ratio_q, r2_q;

  assign adv           = ~vld_q[L-1] | m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[L-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      semi_q  <= g2e_pkg::AXIS_RESET;
      ratio_q <= g2e_pkg::RATIO_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        g2e_pkg::CFG_SEMI_MAJOR: semi_q  <= cfg_wdata_i;
        g2e_pkg::CFG_AXIS_RATIO: ratio_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    r2_q <= g2e_pkg::RATIO_W'((NW'(ratio_q) * NW'(ratio_q)) >> 32);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[L-2:0], s_axis_tvalid};
    end
  end

  // Input stage: double to Q.30 and fold into the right half plane.
  logic signed [AW-1:0] lat2, lon2, lat_f, lon_f;
  logic                 lat_flip, lon_flip;

  always_comb begin
    lat2 = {{3{s_axis_tdata[30]}}, s_axis_tdata[30:0], 1'b0};
    lon2 = {{2{s_axis_tdata[62]}}, s_axis_tdata[62:31], 1'b0};
    lat_flip = 1'b1;
    lon_flip = 1'b1;
    priority if (lat2 > g2e_pkg::HALF_PI_Q30) begin
      lat_f = lat2 - g2e_pkg::PI_Q30;
    end else if (lat2 < -g2e_pkg::HALF_PI_Q30) begin
      lat_f = lat2 + g2e_pkg::PI_Q30;
    end else begin
      lat_f    = lat2;
      lat_flip = 1'b0;
    end
    priority if (lon2 > g2e_pkg::HALF_PI_Q30) begin
      lon_f = lon2 - g2e_pkg::PI_Q30;
    end else if (lon2 < -g2e_pkg::HALF_PI_Q30) begin
      lon_f = lon2 + g2e_pkg::PI_Q30;
    end else begin
      lon_f    = lon2;
      lon_flip = 1'b0;
    end
  end

  logic signed [XW-1:0]  lat_x [0:N];
  logic signed [XW-1:0]  lat_y [0:N];
  logic signed [AW-1:0]  lat_z [0:N];
  logic signed [XW-1:0]  lon_x [0:N];
  logic signed [XW-1:0]  lon_y [0:N];
  logic signed [AW-1:0]  lon_z [0:N];
  logic signed [AW-1:0]  lat_z_q, lon_z_q;
  g2e_pkg::cordic_pl_t   cp_q [0:N];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lat_z_q        <= lat_f;
      lon_z_q        <= lon_f;
      cp_q[0].flip_lat <= lat_flip;
      cp_q[0].flip_lon <= lon_flip;
      cp_q[0].alt    <= $signed(s_axis_tdata[94:63]);
      for (int k = 0; k < N; k++) begin
        cp_q[k+1] <= cp_q[k];
      end
    end
  end

  assign lat_x[0] = g2e_pkg::CORDIC_GAIN;
  assign lat_y[0] = '0;
  assign lat_z[0] = lat_z_q;
  assign lon_x[0] = g2e_pkg::CORDIC_GAIN;
  assign lon_y[0] = '0;
  assign lon_z[0] = lon_z_q;

  for (genvar k = 0; k < N; k++) begin : g_cordic
    g2e_cordic_cell u_lat (
      .clk_i  (clk_i),
      .en_i   (adv),
      .iter_i (g2e_pkg::ITER_W'(k)),
      .x_i    (lat_x[k]),
      .y_i    (lat_y[k]),
      .z_i    (lat_z[k]),
      .x_o    (lat_x[k+1]),
      .y_o    (lat_y[k+1]),
      .z_o    (lat_z[k+1])
    );
    g2e_cordic_cell u_lon (
      .clk_i  (clk_i),
      .en_i   (adv),
      .iter_i (g2e_pkg::ITER_W'(k)),
      .x_i    (lon_x[k]),
      .y_i    (lon_y[k]),
      .z_i    (lon_z[k]),
      .x_o    (lon_x[k+1]),
      .y_o    (lon_y[k+1]),
      .z_o    (lon_z[k+1])
    );
  end

  // Sign restore and magnitudes.
  logic signed [XW-1:0]     c_w, s_w;
  logic                     p1_c_neg_q, p1_s_neg_q;
  logic [MW-1:0]            p1_ac_q, p1_as_q;
  logic signed [XW-1:0]     p1_cl_q, p1_sl_q;
  logic signed [g2e_pkg::ALT_W-1:0] p1_alt_q;

  assign c_w = cp_q[N].flip_lat ? -lat_x[N] : lat_x[N];
  assign s_w = cp_q[N].flip_lat ? -lat_y[N] : lat_y[N];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_c_neg_q <= c_w[XW-1];
      p1_s_neg_q <= s_w[XW-1];
      p1_ac_q    <= g2e_pkg::mag(c_w);
      p1_as_q    <= g2e_pkg::mag(s_w);
      p1_cl_q    <= cp_q[N].flip_lon ? -lon_x[N] : lon_x[N];
      p1_sl_q    <= cp_q[N].flip_lon ? -lon_y[N] : lon_y[N];
      p1_alt_q   <= cp_q[N].alt;
    end
  end

  // First products.
  logic [MW-1:0]        alt_abs;
  logic [NW-1:0]        p2_ac2_q, p2_as2_q, p2_altc_q, p2_alts_q, p2_numx_q;
  logic [MW-1:0]        p2_zt_q;
  logic                 p2_c_neg_q, p2_s_neg_q, p2_alt_neg_q;
  logic signed [XW-1:0] p2_cl_q, p2_sl_q;

  assign alt_abs = p1_alt_q[g2e_pkg::ALT_W-1] ? MW'(-p1_alt_q) : MW'(p1_alt_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_ac2_q     <= NW'(p1_ac_q) * NW'(p1_ac_q);
      p2_as2_q     <= NW'(p1_as_q) * NW'(p1_as_q);
      p2_altc_q    <= NW'(alt_abs) * NW'(p1_ac_q);
      p2_alts_q    <= NW'(alt_abs) * NW'(p1_as_q);
      p2_numx_q    <= NW'(semi_q) * NW'(p1_ac_q);
      p2_zt_q      <= MW'((NW'(r2_q) * NW'(p1_as_q)) >> 32);
      p2_c_neg_q   <= p1_c_neg_q;
      p2_s_neg_q   <= p1_s_neg_q;
      p2_alt_neg_q <= p1_alt_q[g2e_pkg::ALT_W-1];
      p2_cl_q      <= p1_cl_q;
      p2_sl_q      <= p1_sl_q;
    end
  end

  // Radicand and second products.
  logic [NW-1:0]     sq_rad  [0:NS];
  logic [g2e_pkg::SQ_REM_W-1:0] sq_rem [0:NS];
  logic [g2e_pkg::ROOT_W-1:0]   sq_root [0:NS];
  logic [NW-1:0]     p3_rad_q;
  g2e_pkg::sqrt_pl_t sp_q [0:NS];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_rad_q        <= p2_ac2_q + NW'(p2_as2_q >> 32) * NW'(r2_q);
      sp_q[0].num_z   <= NW'(semi_q) * NW'(p2_zt_q);
      sp_q[0].num_x   <= p2_numx_q;
      sp_q[0].altc    <= RW'((p2_altc_q + g2e_pkg::ROUND_HALF) >> 30);
      sp_q[0].alts    <= RW'((p2_alts_q + g2e_pkg::ROUND_HALF) >> 30);
      sp_q[0].c_neg   <= p2_c_neg_q;
      sp_q[0].s_neg   <= p2_s_neg_q;
      sp_q[0].xa_neg  <= p2_alt_neg_q ^ p2_c_neg_q;
      sp_q[0].za_neg  <= p2_alt_neg_q ^ p2_s_neg_q;
      sp_q[0].cl      <= p2_cl_q;
      sp_q[0].sl      <= p2_sl_q;
      for (int k = 0; k < NS; k++) begin
        sp_q[k+1] <= sp_q[k];
      end
    end
  end

  assign sq_rad[0]  = p3_rad_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    g2e_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rad_i  (sq_rad[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .rad_o  (sq_rad[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1])
    );
  end

  // Divider setup: rounding offset and overflow of the top quotient bits.
  localparam int HI_W = NW - ND;
  logic [g2e_pkg::ROOT_W-1:0] den_w;
  logic [NW-1:0]              nx_w, nz_w;
  logic [NW-1:0]              dx_num [0:ND];
  logic [g2e_pkg::DREM_W-1:0] dx_rem [0:ND];
  logic [ND-1:0]              dx_quo [0:ND];
  logic [NW-1:0]              dz_num [0:ND];
  logic [g2e_pkg::DREM_W-1:0] dz_rem [0:ND];
  logic [ND-1:0]              dz_quo [0:ND];
  logic [NW-1:0]              p4_nx_q, p4_nz_q;
  logic [g2e_pkg::DREM_W-1:0] p4_rx_q, p4_rz_q;
  g2e_pkg::div_pl_t           dp_q [0:ND];

  always_comb begin
    den_w = (sq_root[NS] == '0) ? g2e_pkg::ROOT_W'(1) : sq_root[NS];
    nx_w  = sp_q[NS].num_x + NW'(den_w >> 1);
    nz_w  = sp_q[NS].num_z + NW'(den_w >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p4_nx_q        <= {nx_w[ND-1:0], HI_W'(0)};
      p4_nz_q        <= {nz_w[ND-1:0], HI_W'(0)};
      p4_rx_q        <= g2e_pkg::DREM_W'(nx_w[NW-1:ND]);
      p4_rz_q        <= g2e_pkg::DREM_W'(nz_w[NW-1:ND]);
      dp_q[0].ovf_x  <= g2e_pkg::ROOT_W'(nx_w[NW-1:ND]) >= den_w;
      dp_q[0].ovf_z  <= g2e_pkg::ROOT_W'(nz_w[NW-1:ND]) >= den_w;
      dp_q[0].den    <= den_w;
      dp_q[0].c_neg  <= sp_q[NS].c_neg;
      dp_q[0].s_neg  <= sp_q[NS].s_neg;
      dp_q[0].xa_neg <= sp_q[NS].xa_neg;
      dp_q[0].za_neg <= sp_q[NS].za_neg;
      dp_q[0].altc   <= sp_q[NS].altc;
      dp_q[0].alts   <= sp_q[NS].alts;
      dp_q[0].cl     <= sp_q[NS].cl;
      dp_q[0].sl     <= sp_q[NS].sl;
      for (int k = 0; k < ND; k++) begin
        dp_q[k+1] <= dp_q[k];
      end
    end
  end

  assign dx_num[0] = p4_nx_q;
  assign dx_rem[0] = p4_rx_q;
  assign dx_quo[0] = '0;
  assign dz_num[0] = p4_nz_q;
  assign dz_rem[0] = p4_rz_q;
  assign dz_quo[0] = '0;

  for (genvar k = 0; k < ND; k++) begin : g_div
    g2e_div_cell u_x (
      .clk_i (clk_i),
      .en_i  (adv),
      .den_i (dp_q[k].den),
      .num_i (dx_num[k]),
      .rem_i (dx_rem[k]),
      .quo_i (dx_quo[k]),
      .num_o (dx_num[k+1]),
      .rem_o (dx_rem[k+1]),
      .quo_o (dx_quo[k+1])
    );
    g2e_div_cell u_z (
      .clk_i (clk_i),
      .en_i  (adv),
      .den_i (dp_q[k].den),
      .num_i (dz_num[k]),
      .rem_i (dz_rem[k]),
      .quo_i (dz_quo[k]),
      .num_o (dz_num[k+1]),
      .rem_o (dz_rem[k+1]),
      .quo_o (dz_quo[k+1])
    );
  end

  // Surface point plus altitude along the normal.
  logic [ND-1:0]        xm_w, zm_w;
  logic signed [SW-1:0] xs_w, zs_w, xa_w, za_w;
  logic signed [SW-1:0] p5_xloc_q, p5_z_q;
  logic signed [XW-1:0] p5_cl_q, p5_sl_q;

  always_comb begin
    xm_w = (dp_q[ND].ovf_x || dx_quo[ND] > g2e_pkg::QUO_LIMIT) ?
           g2e_pkg::QUO_LIMIT : dx_quo[ND];
    zm_w = (dp_q[ND].ovf_z || dz_quo[ND] > g2e_pkg::QUO_LIMIT) ?
           g2e_pkg::QUO_LIMIT : dz_quo[ND];
    xs_w = dp_q[ND].c_neg ? -$signed(SW'(xm_w)) : $signed(SW'(xm_w));
    zs_w = dp_q[ND].s_neg ? -$signed(SW'(zm_w)) : $signed(SW'(zm_w));
    xa_w = dp_q[ND].xa_neg ? -$signed(SW'(dp_q[ND].altc)) : $signed(SW'(dp_q[ND].altc));
    za_w = dp_q[ND].za_neg ? -$signed(SW'(dp_q[ND].alts)) : $signed(SW'(dp_q[ND].alts));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p5_xloc_q <= g2e_pkg::clamp(xs_w + xa_w, g2e_pkg::INNER_LIMIT);
      p5_z_q    <= g2e_pkg::clamp(zs_w + za_w, g2e_pkg::OUT_LIMIT);
      p5_cl_q   <= dp_q[ND].cl;
      p5_sl_q   <= dp_q[ND].sl;
    end
  end

  // Longitude rotation.
  logic [RW-1:0]        xl_abs;
  logic [NW-1:0]        p6_px_q, p6_py_q;
  logic                 p6_xneg_q, p6_yneg_q;
  logic signed [SW-1:0] p6_z_q;

  assign xl_abs = p5_xloc_q[SW-1] ? RW'(-p5_xloc_q) : RW'(p5_xloc_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p6_px_q   <= NW'(xl_abs) * NW'(g2e_pkg::mag(p5_cl_q));
      p6_py_q   <= NW'(xl_abs) * NW'(g2e_pkg::mag(p5_sl_q));
      p6_xneg_q <= p5_xloc_q[SW-1] ^ p5_cl_q[XW-1];
      p6_yneg_q <= p5_xloc_q[SW-1] ^ p5_sl_q[XW-1];
      p6_z_q    <= p5_z_q;
    end
  end

  logic [RW-1:0]        rx_w, ry_w;
  logic signed [SW-1:0] sx_w, sy_w, cx_w, cy_w;
  logic [PW-1:0]        out_x_q, out_y_q, out_z_q;

  always_comb begin
    rx_w = RW'((p6_px_q + g2e_pkg::ROUND_HALF) >> 30);
    ry_w = RW'((p6_py_q + g2e_pkg::ROUND_HALF) >> 30);
    sx_w = p6_xneg_q ? -$signed(SW'(rx_w)) : $signed(SW'(rx_w));
    sy_w = p6_yneg_q ? -$signed(SW'(ry_w)) : $signed(SW'(ry_w));
    cx_w = g2e_pkg::clamp(sx_w, g2e_pkg::OUT_LIMIT);
    cy_w = g2e_pkg::clamp(sy_w, g2e_pkg::OUT_LIMIT);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_x_q <= cx_w[PW-1:0];
      out_y_q <= cy_w[PW-1:0];
      out_z_q <= p6_z_q[PW-1:0];
    end
  end

  assign m_axis_tdata = {7'd0, out_z_q, out_y_q, out_x_q};

endmodule
